// ===== sv/pcmcvt_pkg.sv =====
// ----------------------------------------------------------------------------
// pcmcvt_pkg
// Shared types, register codes and helpers of the PCM sample format converter.
// ----------------------------------------------------------------------------
package pcmcvt_pkg;

  localparam int unsigned WordWidth = 16;
  localparam int unsigned ByteWidth = 8;
  localparam int unsigned CfgIdxWidth = 3;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SRC_IS_16BIT   = 3'd0,
    REG_SRC_IS_SIGNED  = 3'd1,
    REG_SRC_IS_SWAPPED = 3'd2,
    REG_SRC_IS_STEREO  = 3'd3,
    REG_DST_IS_16BIT   = 3'd4,
    REG_DST_IS_SIGNED  = 3'd5,
    REG_DST_IS_SWAPPED = 3'd6,
    REG_DST_IS_STEREO  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic src_is_16bit;
    logic src_is_signed;
    logic src_is_swapped;
    logic src_is_stereo;
    logic dst_is_16bit;
    logic dst_is_signed;
    logic dst_is_swapped;
    logic dst_is_stereo;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    src_is_16bit:   1'b1,
    src_is_signed:  1'b1,
    src_is_swapped: 1'b0,
    src_is_stereo:  1'b1,
    dst_is_16bit:   1'b1,
    dst_is_signed:  1'b1,
    dst_is_swapped: 1'b0,
    dst_is_stereo:  1'b1
  };

  localparam logic [WordWidth-1:0] SignBit16 = 16'h8000;
  localparam logic [WordWidth-1:0] SignBit16Swapped = 16'h0080;
  localparam logic [ByteWidth-1:0] SignBit8 = 8'h80;

  typedef struct packed {
    logic [WordWidth-1:0] left_word;
    logic [WordWidth-1:0] right_word;
    logic                 end_of_block;
  } frame_t;

  function automatic logic [WordWidth-1:0] swap_bytes(input logic [WordWidth-1:0] w);
    return {w[ByteWidth-1:0], w[WordWidth-1:ByteWidth]};
  endfunction

endpackage

// ===== sv/pcm_sample_format_converter.sv =====
// ----------------------------------------------------------------------------
// pcm_sample_format_converter
// Converts PCM frames between 8/16 bit, signed/unsigned, native/swapped and
// mono/stereo formats, one frame per clock.
// ----------------------------------------------------------------------------
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+--------------------------------------
//   frame in | start, busy               | left_word, right_word, end_of_block
//   result   | done (one-cycle strobe)   | out_left, out_right, out_end_of_block
//   config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// A frame is taken on every cycle that start is high and busy is low; its
// result strobes on done after the input register, the combinational convert
// and the result register, so the sustained rate is one frame per clock.
// busy is set during reset and cleared at the first edge with rst low.
// The result side cannot stall.
//
module pcm_sample_format_converter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [pcmcvt_pkg::WordWidth-1:0]    left_word,
  input  logic [pcmcvt_pkg::WordWidth-1:0]    right_word,
  input  logic                                end_of_block,
  output logic                                done,
  output logic [pcmcvt_pkg::WordWidth-1:0]    out_left,
  output logic [pcmcvt_pkg::WordWidth-1:0]    out_right,
  output logic                                out_end_of_block,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pcmcvt_pkg::CfgIdxWidth-1:0]  cfg_index,
  input  logic                                cfg_data
);

  pcmcvt_pkg::cfg_t                  cfg;
  pcmcvt_pkg::frame_t                frame;
  logic                              frame_valid;
  logic [pcmcvt_pkg::WordWidth-1:0]  conv_left;
  logic [pcmcvt_pkg::WordWidth-1:0]  conv_right;
  logic                              accept;

  assign cfg_ready = !busy;
  assign accept    = start && !busy;

  pcmcvt_cfg_regs u_cfg_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b1;
      frame_valid <= 1'b0;
      done        <= 1'b0;
    end else begin
      busy        <= 1'b0;
      frame_valid <= accept;
      done        <= frame_valid;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (accept) begin
      frame.left_word    <= left_word;
      frame.right_word   <= right_word;
      frame.end_of_block <= end_of_block;
    end
  end

  pcmcvt_convert u_convert (
    .cfg        (cfg),
    .frame      (frame),
    .conv_left  (conv_left),
    .conv_right (conv_right)
  );

  // result register
  always_ff @(posedge clk) begin
    if (frame_valid) begin
      out_left         <= conv_left;
      out_right        <= conv_right;
      out_end_of_block <= frame.end_of_block;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##2 done)
    else $error("accepted frame did not produce a result two cycles later");

  a_mono_right_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(cfg.dst_is_stereo)) |-> (out_right == '0))
    else $error("mono result has a nonzero right sample");

  a_byte_high_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(cfg.dst_is_16bit)) |->
      (out_left[pcmcvt_pkg::WordWidth-1:pcmcvt_pkg::ByteWidth] == '0 &&
       out_right[pcmcvt_pkg::WordWidth-1:pcmcvt_pkg::ByteWidth] == '0))
    else $error("8-bit result has a nonzero high byte");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (busy && !done))
    else $error("block not quiet after reset");

endmodule

// ===== sv/pcmcvt_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// pcmcvt_cfg_regs
// Format register bank, written one bit at a time over the config channel.
// ----------------------------------------------------------------------------
module pcmcvt_cfg_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [pcmcvt_pkg::CfgIdxWidth-1:0]  wr_index,
  input  logic                                wr_data,
  output pcmcvt_pkg::cfg_t                    cfg
);

  pcmcvt_pkg::cfg_t cfg_next;

  always_comb begin
    cfg_next = cfg;
    if (wr_en) begin
      unique case (pcmcvt_pkg::cfg_reg_t'(wr_index))
        pcmcvt_pkg::REG_SRC_IS_16BIT:   cfg_next.src_is_16bit   = wr_data;
        pcmcvt_pkg::REG_SRC_IS_SIGNED:  cfg_next.src_is_signed  = wr_data;
        pcmcvt_pkg::REG_SRC_IS_SWAPPED: cfg_next.src_is_swapped = wr_data;
        pcmcvt_pkg::REG_SRC_IS_STEREO:  cfg_next.src_is_stereo  = wr_data;
        pcmcvt_pkg::REG_DST_IS_16BIT:   cfg_next.dst_is_16bit   = wr_data;
        pcmcvt_pkg::REG_DST_IS_SIGNED:  cfg_next.dst_is_signed  = wr_data;
        pcmcvt_pkg::REG_DST_IS_SWAPPED: cfg_next.dst_is_swapped = wr_data;
        pcmcvt_pkg::REG_DST_IS_STEREO:  cfg_next.dst_is_stereo  = wr_data;
        default: cfg_next = cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= pcmcvt_pkg::CfgReset;
    end else begin
      cfg <= cfg_next;
    end
  end

endmodule

// ===== sv/pcmcvt_convert.sv =====
// ----------------------------------------------------------------------------
// pcmcvt_convert
// Combinational conversion of one frame: byte order, width, channel count
// and signedness.
// ----------------------------------------------------------------------------
module pcmcvt_convert (
  input  pcmcvt_pkg::cfg_t                   cfg,
  input  pcmcvt_pkg::frame_t                 frame,
  output logic [pcmcvt_pkg::WordWidth-1:0]   conv_left,
  output logic [pcmcvt_pkg::WordWidth-1:0]   conv_right
);

  logic                                to_mono;
  logic                                flip;
  logic [pcmcvt_pkg::WordWidth-1:0]    nat_l;
  logic [pcmcvt_pkg::WordWidth-1:0]    nat_r;
  logic [pcmcvt_pkg::WordWidth-1:0]    bias_l;
  logic [pcmcvt_pkg::WordWidth-1:0]    bias_r;
  logic [pcmcvt_pkg::WordWidth:0]      sum16;
  logic [pcmcvt_pkg::WordWidth-1:0]    avg16;
  logic [pcmcvt_pkg::WordWidth-1:0]    w16_l;
  logic [pcmcvt_pkg::WordWidth-1:0]    w16_r;
  logic [pcmcvt_pkg::WordWidth-1:0]    flip16;
  logic [pcmcvt_pkg::ByteWidth-1:0]    b_l;
  logic [pcmcvt_pkg::ByteWidth-1:0]    b_r;
  logic [pcmcvt_pkg::ByteWidth-1:0]    bb_l;
  logic [pcmcvt_pkg::ByteWidth-1:0]    bb_r;
  logic [pcmcvt_pkg::ByteWidth:0]      sum8;
  logic [pcmcvt_pkg::ByteWidth-1:0]    avg8;
  logic [pcmcvt_pkg::ByteWidth-1:0]    o8_l;
  logic [pcmcvt_pkg::ByteWidth-1:0]    o8_r;
  logic [pcmcvt_pkg::WordWidth-1:0]    w8_l;
  logic [pcmcvt_pkg::WordWidth-1:0]    w8_r;
  logic [pcmcvt_pkg::WordWidth-1:0]    pre_l;
  logic [pcmcvt_pkg::WordWidth-1:0]    pre_r;

  assign to_mono = cfg.src_is_stereo && !cfg.dst_is_stereo;
  assign flip    = cfg.src_is_signed != cfg.dst_is_signed;

  // 16 to 16 bit path
  always_comb begin
    nat_l  = cfg.src_is_swapped ? pcmcvt_pkg::swap_bytes(frame.left_word)  : frame.left_word;
    nat_r  = cfg.src_is_swapped ? pcmcvt_pkg::swap_bytes(frame.right_word) : frame.right_word;
    // signed halving sum done in offset binary
    bias_l = cfg.src_is_signed ? (nat_l ^ pcmcvt_pkg::SignBit16) : nat_l;
    bias_r = cfg.src_is_signed ? (nat_r ^ pcmcvt_pkg::SignBit16) : nat_r;
    sum16  = {1'b0, bias_l} + {1'b0, bias_r};
    avg16  = sum16[pcmcvt_pkg::WordWidth:1];
    if (cfg.src_is_signed) begin
      avg16 = avg16 ^ pcmcvt_pkg::SignBit16;
    end
    if (to_mono) begin
      w16_l = cfg.dst_is_swapped ? pcmcvt_pkg::swap_bytes(avg16) : avg16;
      w16_r = frame.right_word;
    end else if (cfg.src_is_swapped != cfg.dst_is_swapped) begin
      w16_l = pcmcvt_pkg::swap_bytes(frame.left_word);
      w16_r = pcmcvt_pkg::swap_bytes(frame.right_word);
    end else begin
      w16_l = frame.left_word;
      w16_r = frame.right_word;
    end
    flip16 = '0;
    if (flip) begin
      flip16 = cfg.dst_is_swapped ? pcmcvt_pkg::SignBit16Swapped : pcmcvt_pkg::SignBit16;
    end
    w16_l = w16_l ^ flip16;
    w16_r = w16_r ^ flip16;
  end

  // paths with an 8 bit side
  always_comb begin
    if (cfg.src_is_16bit && !cfg.src_is_swapped) begin
      b_l = frame.left_word[pcmcvt_pkg::WordWidth-1:pcmcvt_pkg::ByteWidth];
      b_r = frame.right_word[pcmcvt_pkg::WordWidth-1:pcmcvt_pkg::ByteWidth];
    end else begin
      b_l = frame.left_word[pcmcvt_pkg::ByteWidth-1:0];
      b_r = frame.right_word[pcmcvt_pkg::ByteWidth-1:0];
    end
    bb_l = cfg.src_is_signed ? (b_l ^ pcmcvt_pkg::SignBit8) : b_l;
    bb_r = cfg.src_is_signed ? (b_r ^ pcmcvt_pkg::SignBit8) : b_r;
    sum8 = {1'b0, bb_l} + {1'b0, bb_r};
    avg8 = sum8[pcmcvt_pkg::ByteWidth:1];
    if (cfg.src_is_signed) begin
      avg8 = avg8 ^ pcmcvt_pkg::SignBit8;
    end
    o8_l = to_mono ? avg8 : b_l;
    o8_r = b_r;
    if (flip) begin
      o8_l = o8_l ^ pcmcvt_pkg::SignBit8;
      o8_r = o8_r ^ pcmcvt_pkg::SignBit8;
    end
    // native 16 bit destination takes the byte in the high half
    if (cfg.dst_is_16bit && !cfg.dst_is_swapped) begin
      w8_l = {o8_l, {pcmcvt_pkg::ByteWidth{1'b0}}};
      w8_r = {o8_r, {pcmcvt_pkg::ByteWidth{1'b0}}};
    end else begin
      w8_l = {{pcmcvt_pkg::ByteWidth{1'b0}}, o8_l};
      w8_r = {{pcmcvt_pkg::ByteWidth{1'b0}}, o8_r};
    end
  end

  always_comb begin
    if (cfg.src_is_16bit && cfg.dst_is_16bit) begin
      pre_l = w16_l;
      pre_r = w16_r;
    end else begin
      pre_l = w8_l;
      pre_r = w8_r;
    end
    conv_left = pre_l;
    if (!cfg.dst_is_stereo) begin
      conv_right = '0;
    end else if (!cfg.src_is_stereo) begin
      conv_right = pre_l;
    end else begin
      conv_right = pre_r;
    end
  end

endmodule
